[sv/vplfm_pkg.sv]
package vplfm_pkg;

    localparam int MD_A_W = 34;
    localparam int MD_B_W = 26;
    localparam int MD_D_W = 32;
    localparam int MD_Q_W = 60;

    // how the multiply-divide unit forms its quotient
    localparam logic [1:0] MD_SERIAL = 2'd0;
    localparam logic [1:0] MD_SHIFT  = 2'd1;
    localparam logic [1:0] MD_RECIP  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [1:0]        kind;
        logic [4:0]        sa;
        logic [31:0]       rm;
        logic [5:0]        sb;
        logic [MD_A_W-1:0] a;
        logic [MD_B_W-1:0] b;
        logic [MD_D_W-1:0] d;
    } md_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [MD_Q_W-1:0] quot;
    } md_rsp_t;

    localparam logic [2:0] CFG_COARSE   = 3'd0;
    localparam logic [2:0] CFG_STEPPED  = 3'd1;
    localparam logic [2:0] CFG_FINE     = 3'd2;
    localparam logic [2:0] CFG_KNOB     = 3'd3;
    localparam logic [2:0] CFG_ATTEN    = 3'd4;
    localparam logic [2:0] CFG_AMOUNT   = 3'd5;
    localparam logic [2:0] CFG_SOFT     = 3'd6;
    localparam logic [2:0] CFG_HPC      = 3'd7;

    localparam logic [1:0] SYNC_NONE = 2'd0;
    localparam logic [1:0] SYNC_HARD = 2'd1;
    localparam logic [1:0] SYNC_SOFT = 2'd2;

    localparam logic [23:0] HPC_RESET   = 24'd16760000;
    localparam int          C4_Q16      = 17145892;
    localparam int          LN2_Q30     = 744261118;
    localparam int          ATAN_C0     = 51472;
    localparam int          ATAN_C1     = 17891;
    localparam int          HALF_PI_Q16 = 102944;
    localparam int          FREQ_MIN    = 2048;
    localparam int          FREQ_MAX    = 5120000;
    localparam int          FINE_DIV    = 75;
    localparam int          HP_DIV      = 16777216;
    localparam int          BUS_DIV     = 2621440;
    localparam int          UNIT_Q16    = 65536;
    localparam int          SCAN_DIV    = 5120;

    // shift and reciprocal pairs for the constant divisors
    localparam logic [4:0]  HP_SH       = 5'd24;
    localparam logic [4:0]  UNIT_SH     = 5'd16;
    localparam logic [31:0] FINE_RCP    = 32'd13982;
    localparam logic [5:0]  FINE_RCP_SH = 6'd20;
    localparam logic [4:0]  SCAN_PRE    = 5'd10;
    localparam logic [31:0] SCAN_RCP    = 32'd3355444;
    localparam logic [5:0]  SCAN_RCP_SH = 6'd24;
    localparam logic [4:0]  BUS_PRE     = 5'd19;
    localparam logic [31:0] BUS_RCP     = 32'd3435973837;
    localparam logic [5:0]  BUS_RCP_SH  = 6'd34;

    function automatic logic [17:0] exp_entry(input int k, input int bits);
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        t = (64'(k) * 64'(LN2_Q30) + (64'd1 << (bits - 1))) >> bits;
        term = 64'd1 << 30;
        sum = term;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * t) >> 30) / 64'(n);
            sum = sum + term;
        end
        return 18'((sum + 64'd8192) >> 14);
    endfunction

    function automatic logic [16:0] atan_k(input logic [16:0] v);
        logic [33:0] m;
        m = 34'(ATAN_C1) * (34'd65536 - 34'(v)) + 34'd32768;
        return 17'(34'(ATAN_C0) + (m >> 16));
    endfunction

    function automatic logic [16:0] atan_r(input logic [16:0] v, input logic [16:0] k);
        logic [33:0] m;
        m = 34'(v) * 34'(k) + 34'd32768;
        return 17'(m >> 16);
    endfunction

endpackage

[sv/vplfm_muldiv.sv]
module vplfm_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  vplfm_pkg::md_req_t req,
    output vplfm_pkg::md_rsp_t rsp
);
    import vplfm_pkg::*;

    localparam logic [2:0] MD_IDLE = 3'd0;
    localparam logic [2:0] MD_MUL  = 3'd1;
    localparam logic [2:0] MD_DIV  = 3'd2;
    localparam logic [2:0] MD_FIN  = 3'd3;
    localparam logic [2:0] MD_SCL  = 3'd4;
    localparam logic [2:0] MD_RCP  = 3'd5;
    localparam logic [5:0] LAST_STEP = 6'(MD_Q_W - 1);

    logic [2:0]        st_reg;
    logic [5:0]        cnt_reg;
    logic              done_reg;
    logic [MD_A_W-1:0] a_reg;
    logic [MD_B_W-1:0] b_reg;
    logic [MD_D_W-1:0] d_reg;
    logic [1:0]        kind_reg;
    logic [4:0]        sa_reg;
    logic [31:0]       rm_reg;
    logic [5:0]        sb_reg;
    logic [MD_Q_W-1:0] num_reg;
    logic [MD_D_W:0]   rem_reg;
    logic [MD_Q_W-1:0] quot_reg;
    logic              neg_reg;

    logic signed [MD_Q_W-1:0] prod;
    logic [MD_Q_W-1:0]        mag;
    logic [MD_D_W:0]          rem_sh;
    logic                     qbit;
    logic [63:0]              rprod;

    assign prod   = $signed(a_reg) * $signed(b_reg);
    assign mag    = prod[MD_Q_W-1] ? MD_Q_W'(-prod) : MD_Q_W'(prod);
    assign rem_sh = {rem_reg[MD_D_W-1:0], num_reg[MD_Q_W-1]};
    assign qbit   = rem_sh >= {1'b0, d_reg};
    assign rprod  = 64'(num_reg[31:0]) * 64'(rm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= MD_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                MD_IDLE:
                begin
                    if (req.start)
                        st_reg <= MD_MUL;
                end
                MD_MUL:
                begin
                    cnt_reg <= '0;
                    st_reg  <= (kind_reg == MD_SERIAL) ? MD_DIV : MD_SCL;
                end
                MD_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == LAST_STEP)
                        st_reg <= MD_FIN;
                end
                MD_SCL:
                begin
                    st_reg <= (kind_reg == MD_RECIP) ? MD_RCP : MD_FIN;
                end
                MD_RCP:
                begin
                    st_reg <= MD_FIN;
                end
                MD_FIN:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= MD_IDLE;
                end
                default: st_reg <= MD_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    a_reg    <= req.a;
                    b_reg    <= req.b;
                    d_reg    <= req.d;
                    kind_reg <= req.kind;
                    sa_reg   <= req.sa;
                    rm_reg   <= req.rm;
                    sb_reg   <= req.sb;
                end
            end
            MD_MUL:
            begin
                neg_reg  <= prod[MD_Q_W-1];
                num_reg  <= mag + MD_Q_W'(d_reg >> 1);
                rem_reg  <= '0;
                quot_reg <= '0;
            end
            MD_DIV:
            begin
                rem_reg  <= qbit ? rem_sh - {1'b0, d_reg} : rem_sh;
                num_reg  <= {num_reg[MD_Q_W-2:0], 1'b0};
                quot_reg <= {quot_reg[MD_Q_W-2:0], qbit};
            end
            MD_SCL:
            begin
                num_reg  <= num_reg >> sa_reg;
                quot_reg <= num_reg >> sa_reg;
            end
            MD_RCP:
            begin
                quot_reg <= MD_Q_W'(rprod >> sb_reg);
            end
            MD_FIN:
            begin
                if (neg_reg)
                    quot_reg <= MD_Q_W'(-quot_reg);
            end
            default: ;
        endcase
    end

    assign rsp.busy = st_reg != MD_IDLE;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[sv/voice_pitch_linfm_control.sv]
// one item at a time: a new input beat is taken only in idle, after the previous result is issued
// fm drive adds the drive multiply, the atan reciprocal and the normalization divides;
//   constant divisions use a shift or a reciprocal multiply, the atan
//   reciprocal and normalization divides run 60 one-bit steps, 5 to 9 divisions per item
// a new input beat is taken while the previous result still waits at the output
// reset: async active low; registers to defaults, filter and trigger state read as zero
module voice_pitch_linfm_control #(
    parameter int VOICES         = 16,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  voice_index,
    input  logic [15:0] pitch_cv,
    input  logic [15:0] fm_cv,
    input  logic [15:0] scan_cv,
    input  logic [15:0] sync_cv,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  voice_out,
    output logic [22:0] frequency,
    output logic [22:0] base_frequency,
    output logic [15:0] scan_position,
    output logic [1:0]  sync_action,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import vplfm_pkg::*;

    localparam int TBL_N = 1 << EXP_TABLE_BITS;
    localparam int RS    = 12 - EXP_TABLE_BITS;
    localparam int AW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [11:0] REM_MASK = 12'((1 << RS) - 1);

    function automatic logic [(TBL_N+1)*18-1:0] build_tbl();
        logic [(TBL_N+1)*18-1:0] r;
        r = '0;
        for (int k = 0; k <= TBL_N; k++)
            r[k*18 +: 18] = exp_entry(k, EXP_TABLE_BITS);
        return r;
    endfunction

    localparam logic [(TBL_N+1)*18-1:0] EXP_TBL = build_tbl();

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_READ   = 5'd1;
    localparam logic [4:0] ST_FINE_W = 5'd2;
    localparam logic [4:0] ST_MANT   = 5'd3;
    localparam logic [4:0] ST_PROD   = 5'd4;
    localparam logic [4:0] ST_BASE   = 5'd5;
    localparam logic [4:0] ST_HP     = 5'd6;
    localparam logic [4:0] ST_HP_W   = 5'd7;
    localparam logic [4:0] ST_BUS    = 5'd8;
    localparam logic [4:0] ST_BUS_W  = 5'd9;
    localparam logic [4:0] ST_DRV    = 5'd10;
    localparam logic [4:0] ST_DRV_W  = 5'd11;
    localparam logic [4:0] ST_INV1   = 5'd12;
    localparam logic [4:0] ST_INV1_W = 5'd13;
    localparam logic [4:0] ST_K1     = 5'd14;
    localparam logic [4:0] ST_R1     = 5'd15;
    localparam logic [4:0] ST_INV2   = 5'd16;
    localparam logic [4:0] ST_INV2_W = 5'd17;
    localparam logic [4:0] ST_K2     = 5'd18;
    localparam logic [4:0] ST_R2     = 5'd19;
    localparam logic [4:0] ST_NORM   = 5'd20;
    localparam logic [4:0] ST_NORM_W = 5'd21;
    localparam logic [4:0] ST_FM     = 5'd22;
    localparam logic [4:0] ST_FM_W   = 5'd23;
    localparam logic [4:0] ST_SCAN   = 5'd24;
    localparam logic [4:0] ST_SCAN_W = 5'd25;
    localparam logic [4:0] ST_DONE   = 5'd26;

    logic [4:0] st_reg;
    logic       out_valid_reg;
    logic [VOICES-1:0] vbit_reg;

    logic signed [15:0] coarse_reg;
    logic               stepped_reg;
    logic signed [11:0] fine_reg;
    logic [15:0]        knob_reg;
    logic signed [15:0] atten_reg;
    logic [15:0]        amount_reg;
    logic               soft_reg;
    logic [23:0]        hpc_reg;

    logic [32:0] hp_mem [VOICES];
    logic [32:0] rdata_reg;

    logic [3:0]         voice_reg;
    logic signed [15:0] pcv_reg;
    logic signed [15:0] fcv_reg;
    logic signed [15:0] scv_reg;
    logic signed [15:0] ycv_reg;
    logic               vok_reg;
    logic signed [31:0] s_reg;
    logic               trig_reg;
    logic [15:0]        q_reg;
    logic [17:0]        mant_reg;
    logic [42:0]        prod_reg;
    logic [22:0]        base_reg;
    logic signed [33:0] bus_reg;
    logic [31:0]        ax_reg;
    logic               tneg_reg;
    logic               big_reg;
    logic [16:0]        inv_reg;
    logic [16:0]        k_reg;
    logic signed [18:0] num_reg;
    logic [16:0]        atd_reg;
    logic [22:0]        freq_reg;
    logic [15:0]        scan_reg;

    logic [3:0]  vout_reg;
    logic [22:0] fout_reg;
    logic [22:0] bout_reg;
    logic [15:0] sout_reg;
    logic [1:0]  aout_reg;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic                in_acc;
    logic [AW-1:0]       addr;
    logic                vok_in;
    logic signed [MD_Q_W-1:0] mdq;
    logic signed [32:0]  y;
    logic                trig_new;
    logic                fire;
    logic [16:0]         dn;
    logic [18:0]         dd;
    logic signed [20:0]  dn_raw;
    logic [16:0]         cmag;
    logic [16:0]         cround;
    logic signed [17:0]  coarse_eff;
    logic signed [19:0]  p_raw;
    logic signed [19:0]  p_cl;
    logic [11:0]         fr12;
    logic [EXP_TABLE_BITS-1:0] tidx;
    logic [EXP_TABLE_BITS:0]   tidx1;
    logic [17:0]         t0;
    logic [17:0]         t1;
    logic [29:0]         iprod;
    logic [5:0]          sh;
    logic [43:0]         rnd;
    logic [43:0]         braw;
    logic signed [33:0]  tq;
    logic [31:0]         tabs;
    logic [16:0]         atv;
    logic [17:0]         amag;
    logic [16:0]         ar1;
    logic [16:0]         ar2;
    logic signed [39:0]  fsum;
    logic signed [39:0]  s_new40;
    logic signed [39:0]  ssum;

    assign in_ready  = st_reg == ST_IDLE;
    assign in_acc    = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign addr      = voice_reg[AW-1:0];
    assign vok_in    = {1'b0, voice_index} < 5'(VOICES);
    assign mdq       = $signed(md_rsp.quot);

    assign y = $signed({{9{fcv_reg[15]}}, fcv_reg, 8'b0}) - $signed({s_reg[31], s_reg});

    assign trig_new = trig_reg ? !(ycv_reg <= 16'sd0) : (ycv_reg >= 16'sd1024);
    assign fire     = !trig_reg && (ycv_reg >= 16'sd1024);

    assign dn_raw = $signed({2'b0, 19'(amount_reg) * 19'd5}) - 21'sd262144;
    assign dn     = (dn_raw < 0) ? 17'd0 : ((dn_raw > 21'sd65536) ? 17'd65536 : 17'(dn_raw));
    assign dd     = 19'd65536 + 19'(dn) * 19'd3;

    assign cmag       = coarse_reg[15] ? 17'(-$signed({coarse_reg[15], coarse_reg}))
                                       : {1'b0, coarse_reg};
    assign cround     = ((cmag + 17'd512) >> 10) << 10;
    assign coarse_eff = !stepped_reg ? 18'(coarse_reg)
                      : (coarse_reg[15] ? -$signed({1'b0, cround}) : $signed({1'b0, cround}));
    assign p_raw = 20'(coarse_eff) + 20'($signed(mdq[15:0])) + 20'(pcv_reg);
    assign p_cl  = (p_raw < -20'sd24576) ? -20'sd24576
                 : ((p_raw > 20'sd16384) ? 20'sd16384 : p_raw);

    assign fr12  = {q_reg[9:0], 2'b00};
    assign tidx  = fr12[11:RS];
    assign tidx1 = {1'b0, tidx} + 1'b1;
    assign t0    = EXP_TBL[18*tidx +: 18];
    assign t1    = EXP_TBL[18*tidx1 +: 18];
    assign iprod = 30'(t1 - t0) * 30'(fr12 & REM_MASK);

    assign sh   = 6'd48 - q_reg[15:10];
    assign rnd  = 44'(prod_reg) + (44'd1 << (sh - 6'd1));
    assign braw = rnd >> sh;

    assign tq   = mdq[33:0];
    assign tabs = tq[33] ? 32'(-tq) : 32'(tq);

    assign atv  = big_reg ? inv_reg : ax_reg[16:0];
    assign ar1  = atan_r(atv, k_reg);
    assign amag = big_reg ? 18'(HALF_PI_Q16) - 18'(ar1) : 18'(ar1);
    assign ar2  = atan_r(inv_reg, k_reg);

    assign fsum    = $signed({17'b0, base_reg}) + mdq[39:0];
    assign s_new40 = $signed({{16{fcv_reg[15]}}, fcv_reg, 8'b0}) - mdq[39:0];
    assign ssum    = $signed({24'b0, knob_reg}) + mdq[39:0];

    always_comb
    begin
        md_req = '0;
        unique case (st_reg)
            ST_READ:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_RECIP;
                md_req.rm = FINE_RCP;
                md_req.sb = FINE_RCP_SH;
                md_req.a = MD_A_W'(fine_reg);
                md_req.b = MD_B_W'(4);
                md_req.d = MD_D_W'(FINE_DIV);
            end
            ST_HP:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_SHIFT;
                md_req.sa = HP_SH;
                md_req.a = MD_A_W'(y);
                md_req.b = MD_B_W'(hpc_reg);
                md_req.d = MD_D_W'(HP_DIV);
            end
            ST_BUS:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_RECIP;
                md_req.sa = BUS_PRE;
                md_req.rm = BUS_RCP;
                md_req.sb = BUS_RCP_SH;
                md_req.a = MD_A_W'(y);
                md_req.b = MD_B_W'(amount_reg);
                md_req.d = MD_D_W'(BUS_DIV);
            end
            ST_DRV:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_SHIFT;
                md_req.sa = UNIT_SH;
                md_req.a = bus_reg;
                md_req.b = MD_B_W'(dd);
                md_req.d = MD_D_W'(UNIT_Q16);
            end
            ST_INV1:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_SERIAL;
                md_req.a = MD_A_W'(UNIT_Q16);
                md_req.b = MD_B_W'(UNIT_Q16);
                md_req.d = ax_reg;
            end
            ST_INV2:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_SERIAL;
                md_req.a = MD_A_W'(UNIT_Q16);
                md_req.b = MD_B_W'(UNIT_Q16);
                md_req.d = MD_D_W'(dd);
            end
            ST_NORM:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_SERIAL;
                md_req.a = MD_A_W'(num_reg);
                md_req.b = MD_B_W'(UNIT_Q16);
                md_req.d = MD_D_W'(atd_reg);
            end
            ST_FM:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_SHIFT;
                md_req.sa = UNIT_SH;
                md_req.a = bus_reg;
                md_req.b = MD_B_W'(base_reg);
                md_req.d = MD_D_W'(UNIT_Q16);
            end
            ST_SCAN:
            begin
                md_req.start = 1'b1;
                md_req.kind = MD_RECIP;
                md_req.sa = SCAN_PRE;
                md_req.rm = SCAN_RCP;
                md_req.sb = SCAN_RCP_SH;
                md_req.a = MD_A_W'(scv_reg);
                md_req.b = MD_B_W'(atten_reg);
                md_req.d = MD_D_W'(SCAN_DIV);
            end
            default: ;
        endcase
    end

    vplfm_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            vbit_reg      <= '0;
            coarse_reg    <= '0;
            stepped_reg   <= 1'b0;
            fine_reg      <= '0;
            knob_reg      <= '0;
            atten_reg     <= '0;
            amount_reg    <= '0;
            soft_reg      <= 1'b0;
            hpc_reg       <= HPC_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_COARSE:  coarse_reg  <= cfg_data[15:0];
                    CFG_STEPPED: stepped_reg <= cfg_data[0];
                    CFG_FINE:    fine_reg    <= cfg_data[11:0];
                    CFG_KNOB:    knob_reg    <= cfg_data[15:0];
                    CFG_ATTEN:   atten_reg   <= cfg_data[15:0];
                    CFG_AMOUNT:  amount_reg  <= cfg_data[15:0];
                    CFG_SOFT:    soft_reg    <= cfg_data[0];
                    CFG_HPC:     hpc_reg     <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && st_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            unique case (st_reg)
                ST_IDLE:   if (in_acc) st_reg <= ST_READ;
                ST_READ:   st_reg <= ST_FINE_W;
                ST_FINE_W: if (md_rsp.done) st_reg <= ST_MANT;
                ST_MANT:   st_reg <= ST_PROD;
                ST_PROD:   st_reg <= ST_BASE;
                ST_BASE:   st_reg <= ST_HP;
                ST_HP:     st_reg <= ST_HP_W;
                ST_HP_W:
                begin
                    if (md_rsp.done)
                    begin
                        st_reg <= ST_BUS;
                        if (vok_reg)
                            vbit_reg[addr] <= 1'b1;
                    end
                end
                ST_BUS:    st_reg <= ST_BUS_W;
                ST_BUS_W:
                begin
                    if (md_rsp.done)
                        st_reg <= (dn != 17'd0 && mdq != 0) ? ST_DRV : ST_FM;
                end
                ST_DRV:    st_reg <= ST_DRV_W;
                ST_DRV_W:
                begin
                    if (md_rsp.done)
                        st_reg <= (tabs > 32'd65536) ? ST_INV1 : ST_K1;
                end
                ST_INV1:   st_reg <= ST_INV1_W;
                ST_INV1_W: if (md_rsp.done) st_reg <= ST_K1;
                ST_K1:     st_reg <= ST_R1;
                ST_R1:     st_reg <= ST_INV2;
                ST_INV2:   st_reg <= ST_INV2_W;
                ST_INV2_W: if (md_rsp.done) st_reg <= ST_K2;
                ST_K2:     st_reg <= ST_R2;
                ST_R2:     st_reg <= ST_NORM;
                ST_NORM:   st_reg <= ST_NORM_W;
                ST_NORM_W: if (md_rsp.done) st_reg <= ST_FM;
                ST_FM:     st_reg <= ST_FM_W;
                ST_FM_W:   if (md_rsp.done) st_reg <= ST_SCAN;
                ST_SCAN:   st_reg <= ST_SCAN_W;
                ST_SCAN_W: if (md_rsp.done) st_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        st_reg        <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath and state memory
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            voice_reg <= voice_index;
            pcv_reg   <= pitch_cv;
            fcv_reg   <= fm_cv;
            scv_reg   <= scan_cv;
            ycv_reg   <= sync_cv;
            vok_reg   <= vok_in;
            rdata_reg <= hp_mem[voice_index[AW-1:0]];
        end

        unique case (st_reg)
            ST_READ:
            begin
                s_reg    <= (vok_reg && vbit_reg[addr]) ? rdata_reg[31:0] : 32'sd0;
                trig_reg <= vok_reg && vbit_reg[addr] && rdata_reg[32];
            end
            ST_FINE_W: if (md_rsp.done) q_reg <= 16'(p_cl + 20'sd24576);
            ST_MANT:   mant_reg <= t0 + 18'(iprod >> RS);
            ST_PROD:   prod_reg <= 43'(C4_Q16) * 43'(mant_reg);
            ST_BASE:
            begin
                if (braw < 44'(FREQ_MIN))
                    base_reg <= 23'(FREQ_MIN);
                else if (braw > 44'(FREQ_MAX))
                    base_reg <= 23'(FREQ_MAX);
                else
                    base_reg <= braw[22:0];
            end
            ST_HP_W:
            begin
                if (md_rsp.done && vok_reg)
                    hp_mem[addr] <= {trig_new, s_new40[31:0]};
            end
            ST_BUS_W:  if (md_rsp.done) bus_reg <= mdq[33:0];
            ST_DRV_W:
            begin
                if (md_rsp.done)
                begin
                    ax_reg   <= tabs;
                    tneg_reg <= tq[33];
                    big_reg  <= tabs > 32'd65536;
                end
            end
            ST_INV1_W: if (md_rsp.done) inv_reg <= mdq[16:0];
            ST_K1:     k_reg <= atan_k(atv);
            ST_R1:     num_reg <= tneg_reg ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
            ST_INV2_W: if (md_rsp.done) inv_reg <= mdq[16:0];
            ST_K2:     k_reg <= atan_k(inv_reg);
            ST_R2:     atd_reg <= 17'(HALF_PI_Q16) - ar2;
            ST_NORM_W: if (md_rsp.done) bus_reg <= mdq[33:0];
            ST_FM_W:
            begin
                if (md_rsp.done)
                begin
                    if (fsum < 40'sd2048)
                        freq_reg <= 23'(FREQ_MIN);
                    else if (fsum > 40'sd5120000)
                        freq_reg <= 23'(FREQ_MAX);
                    else
                        freq_reg <= fsum[22:0];
                end
            end
            ST_SCAN_W:
            begin
                if (md_rsp.done)
                begin
                    if (ssum < 0)
                        scan_reg <= 16'd0;
                    else if (ssum > 40'sd65535)
                        scan_reg <= 16'hFFFF;
                    else
                        scan_reg <= ssum[15:0];
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    vout_reg <= voice_reg;
                    fout_reg <= freq_reg;
                    bout_reg <= base_reg;
                    sout_reg <= scan_reg;
                    aout_reg <= fire ? (soft_reg ? SYNC_SOFT : SYNC_HARD) : SYNC_NONE;
                end
            end
            default: ;
        endcase
    end

    assign voice_out      = vout_reg;
    assign frequency      = fout_reg;
    assign base_frequency = bout_reg;
    assign scan_position  = sout_reg;
    assign sync_action    = aout_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("multiply-divide started while busy");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> st_reg == ST_READ)
        else $error("accepted beat did not start a read");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (st_reg == ST_FINE_W || st_reg == ST_HP_W || st_reg == ST_BUS_W ||
                         st_reg == ST_DRV_W || st_reg == ST_INV1_W || st_reg == ST_INV2_W ||
                         st_reg == ST_NORM_W || st_reg == ST_FM_W || st_reg == ST_SCAN_W))
        else $error("multiply-divide result arrived outside a wait state");

    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fout_reg >= 23'(FREQ_MIN) && fout_reg <= 23'(FREQ_MAX)))
        else $error("frequency out of range");

endmodule

[test/voice_pitch_linfm_control_tb.sv]
`timescale 1ns / 100ps

module voice_pitch_linfm_control_tb;
    import vplfm_pkg::*;

    localparam int TBL_N = 256;
    localparam longint CYCLE_LIMIT = 5000000;

    typedef struct {
        logic [3:0]         voice;
        logic signed [15:0] pitch;
        logic signed [15:0] fm;
        logic signed [15:0] scan;
        logic signed [15:0] sync;
    } voice_sample_t;

    typedef struct {
        logic [3:0]  voice;
        logic [22:0] freq;
        logic [22:0] base;
        logic [15:0] scan;
        logic [1:0]  action;
    } osc_ctrl_t;

    typedef struct {
        voice_sample_t s;
        bit            typed;
        osc_ctrl_t     r;
    } sample_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  voice_index = '0;
    logic [15:0] pitch_cv = '0;
    logic [15:0] fm_cv = '0;
    logic [15:0] scan_cv = '0;
    logic [15:0] sync_cv = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  voice_out;
    logic [22:0] frequency;
    logic [22:0] base_frequency;
    logic [15:0] scan_position;
    logic [1:0]  sync_action;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    voice_pitch_linfm_control u_top (.*);

    // control register copies
    logic signed [15:0] m_coarse;
    logic               m_stepped;
    logic signed [11:0] m_fine;
    logic [15:0]        m_knob;
    logic signed [15:0] m_atten;
    logic [15:0]        m_amount;
    logic               m_soft;
    logic [23:0]        m_hpc;

    int          hp_state [16];
    bit          trig_high [16];
    longint      exp2_tbl [TBL_N + 1];
    osc_ctrl_t   pending_ctrl [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycles = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint rnd_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void build_exp2_tbl();
        longint unsigned t, term, sum;
        for (int k = 0; k <= TBL_N; k++)
        begin
            t = (longint'(k) * LN2_Q30 + TBL_N / 2) / TBL_N;
            term = 64'd1 << 30;
            sum = term;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * t) >> 30) / n;
                sum += term;
            end
            exp2_tbl[k] = longint'((sum + 8192) >> 14);
        end
    endfunction

    function automatic longint soft_atan(longint x);
        longint ax, r, k, inv;
        ax = x < 0 ? -x : x;
        if (ax <= UNIT_Q16)
        begin
            k = ATAN_C0 + ((ATAN_C1 * (UNIT_Q16 - ax) + 32768) >>> 16);
            r = (ax * k + 32768) >>> 16;
        end
        else
        begin
            inv = ((64'sd1 <<< 32) + ax / 2) / ax;
            k = ATAN_C0 + ((ATAN_C1 * (UNIT_Q16 - inv) + 32768) >>> 16);
            r = HALF_PI_Q16 - ((inv * k + 32768) >>> 16);
        end
        return x < 0 ? -r : r;
    endfunction

    function automatic osc_ctrl_t predict_osc_ctrl(voice_sample_t s);
        osc_ctrl_t    r;
        longint       coarse, p, oct, fr12, idx, rem, mant, base, freq;
        longint       x, y, st, bus, dn, d, scan;
        longint unsigned prod;
        int           sh;
        bit           trig;
        logic [1:0]   action;
        coarse = m_coarse;
        if (m_stepped)
            coarse = rnd_div(coarse, 1024) * 1024;
        p = clip(coarse + rnd_div(longint'(m_fine) * 4, FINE_DIV) + s.pitch, -24576, 16384);
        oct = ((p + 24576) >>> 10) - 24;
        fr12 = ((p + 24576) & 1023) << 2;
        idx = fr12 >> 4;
        rem = fr12 & 15;
        mant = exp2_tbl[idx] + (((exp2_tbl[idx + 1] - exp2_tbl[idx]) * rem) >>> 4);
        prod = longint'(C4_Q16) * mant;
        sh = 24 - oct;
        base = longint'((prod + (64'd1 << (sh - 1))) >> sh);
        base = clip(base, FREQ_MIN, FREQ_MAX);

        st = hp_state[s.voice];
        x = longint'(s.fm) * 256;
        y = x - st;
        st = x - rnd_div(longint'(m_hpc) * y, HP_DIV);
        bus = rnd_div(y * m_amount, BUS_DIV);
        dn = clip(5 * longint'(m_amount) - 262144, 0, UNIT_Q16);
        if (dn > 0 && bus != 0)
        begin
            d = UNIT_Q16 + 3 * dn;
            bus = rnd_div(soft_atan(rnd_div(bus * d, UNIT_Q16)) * UNIT_Q16, soft_atan(d));
        end
        freq = clip(base + rnd_div(base * bus, UNIT_Q16), FREQ_MIN, FREQ_MAX);

        scan = clip(longint'(m_knob) + rnd_div(longint'(s.scan) * m_atten, SCAN_DIV), 0, 65535);

        trig = trig_high[s.voice];
        action = SYNC_NONE;
        if (trig)
        begin
            if (s.sync <= 0)
                trig = 1'b0;
        end
        else if (s.sync >= 1024)
        begin
            trig = 1'b1;
            action = m_soft ? SYNC_SOFT : SYNC_HARD;
        end
        hp_state[s.voice] = int'(st);
        trig_high[s.voice] = trig;

        r.voice = s.voice;
        r.freq = 23'(freq);
        r.base = 23'(base);
        r.scan = 16'(scan);
        r.action = action;
        return r;
    endfunction

    task automatic send_sample(voice_sample_t s, bit typed, osc_ctrl_t typed_r);
        osc_ctrl_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        voice_index <= s.voice;
        pitch_cv <= s.pitch;
        fm_cv <= s.fm;
        scan_cv <= s.scan;
        sync_cv <= s.sync;
        do @(posedge clk); while (!in_ready);
        r = predict_osc_ctrl(s);
        pending_ctrl.push_back(typed ? typed_r : r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_ctrl.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_COARSE:  m_coarse = val[15:0];
            CFG_STEPPED: m_stepped = val[0];
            CFG_FINE:    m_fine = val[11:0];
            CFG_KNOB:    m_knob = val[15:0];
            CFG_ATTEN:   m_atten = val[15:0];
            CFG_AMOUNT:  m_amount = val[15:0];
            CFG_SOFT:    m_soft = val[0];
            CFG_HPC:     m_hpc = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // kind 0 all low, 1 all high, otherwise random; upper bits carry junk
    task automatic write_all_regs(int kind);
        logic [23:0] v [8];
        for (int i = 0; i < 8; i++)
            v[i] = 24'($urandom);
        if (kind == 0)
        begin
            v[CFG_COARSE][15:0] = 16'h8000;
            v[CFG_STEPPED][0] = 1'b0;
            v[CFG_FINE][11:0] = 12'h800;
            v[CFG_KNOB][15:0] = 16'h0000;
            v[CFG_ATTEN][15:0] = 16'h8000;
            v[CFG_AMOUNT][15:0] = 16'h0000;
            v[CFG_SOFT][0] = 1'b0;
            v[CFG_HPC] = 24'h000000;
        end
        else if (kind == 1)
        begin
            v[CFG_COARSE][15:0] = 16'h7fff;
            v[CFG_STEPPED][0] = 1'b1;
            v[CFG_FINE][11:0] = 12'h7ff;
            v[CFG_KNOB][15:0] = 16'hffff;
            v[CFG_ATTEN][15:0] = 16'h7fff;
            v[CFG_AMOUNT][15:0] = 16'hffff;
            v[CFG_SOFT][0] = 1'b1;
            v[CFG_HPC] = 24'hffffff;
        end
        else if ($urandom_range(1))
        begin
            // musically sensible region
            v[CFG_COARSE][15:0] = 16'(int'($urandom_range(40960)) - 24576);
            v[CFG_FINE][11:0] = 12'(int'($urandom_range(3200)) - 1600);
            v[CFG_HPC] = 24'(16700000 + $urandom_range(77215));
        end
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), v[i]);
    endtask

    function automatic voice_sample_t random_sample();
        voice_sample_t s;
        s.voice = 4'($urandom);
        s.pitch = $urandom_range(3) == 0 ? 16'($urandom) : 16'(int'($urandom_range(8192)) - 4096);
        s.fm = 16'($urandom);
        s.scan = 16'($urandom);
        case ($urandom_range(5))
            0: s.sync = 16'($urandom);
            1: s.sync = 16'sd0;
            2: s.sync = 16'sd1024;
            3: s.sync = 16'sd1023;
            4: s.sync = 16'sd1;
            default: s.sync = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
        return s;
    endfunction

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("voice_pitch_linfm_control regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        osc_ctrl_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_ctrl.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: voice %0d", voice_out);
            end
            else
            begin
                e = pending_ctrl.pop_front();
                if (voice_out !== e.voice || frequency !== e.freq || base_frequency !== e.base
                    || scan_position !== e.scan || sync_action !== e.action)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp v%0d f%0d b%0d s%0d a%0d got v%0d f%0d b%0d s%0d a%0d",
                            e.voice, e.freq, e.base, e.scan, e.action, voice_out, frequency,
                            base_frequency, scan_position, sync_action);
                end
            end
        end
    end

    sample_row_t rows [20];

    function automatic sample_row_t row(int v, int p, int f, int sc, int sy, bit typed,
                                        int fr, int bs, int sp, logic [1:0] act);
        sample_row_t w;
        w.s = '{4'(v), 16'(p), 16'(f), 16'(sc), 16'(sy)};
        w.typed = typed;
        w.r = '{4'(v), 23'(fr), 23'(bs), 16'(sp), act};
        return w;
    endfunction

    initial
    begin
        osc_ctrl_t none_r;
        none_r = '{default: '0};
        build_exp2_tbl();
        m_coarse = 0; m_stepped = 0; m_fine = 0; m_knob = 0;
        m_atten = 0; m_amount = 0; m_soft = 0; m_hpc = HPC_RESET;
        foreach (hp_state[i])
        begin
            hp_state[i] = 0;
            trig_high[i] = 0;
        end

        // reset registers: no fm, no scan, hard sync
        rows[0]  = row(0, 0, 0, 0, 0, 1, 66976, 66976, 0, SYNC_NONE);
        rows[1]  = row(1, 16384, 0, 32767, 1024, 1, FREQ_MAX, FREQ_MAX, 0, SYNC_HARD);
        rows[2]  = row(1, 32767, 0, -32768, 1024, 1, FREQ_MAX, FREQ_MAX, 0, SYNC_NONE);
        rows[3]  = row(1, -32768, 0, 0, 0, 1, FREQ_MIN, FREQ_MIN, 0, SYNC_NONE);
        rows[4]  = row(1, -24576, 0, 0, 32767, 1, FREQ_MIN, FREQ_MIN, 0, SYNC_HARD);
        rows[5]  = row(15, 0, 0, 0, 1023, 1, 66976, 66976, 0, SYNC_NONE);
        rows[6]  = row(15, 0, 32767, 0, 1, 0, 0, 0, 0, SYNC_NONE);
        rows[7]  = row(15, 1024, -32768, 0, -32768, 0, 0, 0, 0, SYNC_NONE);
        rows[8]  = row(2, 512, 0, 0, 1024, 0, 0, 0, 0, SYNC_NONE);
        rows[9]  = row(1, 0, 0, 0, -32768, 0, 0, 0, 0, SYNC_NONE);
        // full drive and extreme registers
        rows[10] = row(3, 0, 32767, 32767, 1024, 0, 0, 0, 0, SYNC_NONE);
        rows[11] = row(3, 0, -32768, -32768, 0, 0, 0, 0, 0, SYNC_NONE);
        rows[12] = row(3, 0, 32767, 1, 1024, 0, 0, 0, 0, SYNC_NONE);
        rows[13] = row(4, -1, 0, 0, 1, 0, 0, 0, 0, SYNC_NONE);
        rows[14] = row(4, 1, 1, -1, 1024, 0, 0, 0, 0, SYNC_NONE);
        rows[15] = row(4, -12288, -1, 5120, 0, 0, 0, 0, 0, SYNC_NONE);
        rows[16] = row(5, 16384, 20000, -5120, 2000, 0, 0, 0, 0, SYNC_NONE);
        rows[17] = row(5, -32768, -20000, 12345, -1, 0, 0, 0, 0, SYNC_NONE);
        rows[18] = row(6, 700, 0, 0, 1024, 0, 0, 0, 0, SYNC_NONE);
        rows[19] = row(6, -700, 0, 0, 0, 0, 0, 0, 0, SYNC_NONE);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (i == 10)
            begin
                drain();
                write_all_regs(1);
                write_reg(CFG_COARSE, 24'h000000);
                write_reg(CFG_STEPPED, 24'h000000);
            end
            send_sample(rows[i].s, rows[i].typed, rows[i].r);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_all_regs(ph);
            send_idle_pct = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 21 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 21 : 0;
            for (int n = 0; n < 135; n++)
            begin
                if (ph == 3 && n == 60)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (pending_ctrl.size() > 0)
                        @(posedge clk);
                end
                send_sample(random_sample(), 1'b0, none_r);
            end
        end
        drain();

        if (errors == 0)
            $display("voice_pitch_linfm_control regression: pass");
        else
            $display("voice_pitch_linfm_control regression: fail");
        $finish;
    end

endmodule
